FILE: hdl/box_screen_projection_bounds_defines.svh
// Assertion macros for the screen projection bounds block
`ifndef BOX_SCREEN_PROJECTION_BOUNDS_DEFINES_SVH
`define BOX_SCREEN_PROJECTION_BOUNDS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BSPB_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BSPB_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hdl/bspb_pkg.sv
// Shared constants and types of the screen projection bounds block
`default_nettype none
package bspb_pkg;

   localparam int COORD_WIDTH_DEF     = 32;
   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int PIXEL_FRAC_BITS_DEF = 8;

   localparam int VP_POS_W   = 12;
   localparam int VP_SIZE_W  = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int COEF_IDX_W = 4;
   localparam int COEF_CNT   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_VP_LEFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_TOP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_HEIGHT = 2'd3;

   localparam logic [VP_SIZE_W-1:0] VP_WIDTH_RST  = 13'd640;
   localparam logic [VP_SIZE_W-1:0] VP_HEIGHT_RST = 13'd480;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_BOX  = 1'b1;

   localparam int CORNER_W = 3;
   localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd7;

   // 1e-12 as a denominator
   localparam longint unsigned EPS_DEN = 64'd1000000000000;

   typedef struct packed {
      logic first;
      logic last;
      logic behind;
      logic neg_x;
      logic over_x;
      logic neg_y;
      logic over_y;
   } corner_tag_type;

endpackage
`default_nettype wire

FILE: hdl/bspb_if.sv
// Request and response channel interfaces of the screen projection bounds block
`default_nettype none
interface bspb_req_if #(
   parameter int COORD_WIDTH = bspb_pkg::COORD_WIDTH_DEF
) ();
   import bspb_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [COEF_IDX_W-1:0]         coef_index;
   logic signed [COORD_WIDTH-1:0] coef_value;
   logic signed [COORD_WIDTH-1:0] box_min_x;
   logic signed [COORD_WIDTH-1:0] box_min_y;
   logic signed [COORD_WIDTH-1:0] box_min_z;
   logic signed [COORD_WIDTH-1:0] box_max_x;
   logic signed [COORD_WIDTH-1:0] box_max_y;
   logic signed [COORD_WIDTH-1:0] box_max_z;

   modport source (output valid, mode, coef_index, coef_value, box_min_x, box_min_y,
                   box_min_z, box_max_x, box_max_y, box_max_z, input ready);
   modport sink (input valid, mode, coef_index, coef_value, box_min_x, box_min_y,
                 box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface bspb_rsp_if #(
   parameter int PIXEL_FRAC_BITS = bspb_pkg::PIXEL_FRAC_BITS_DEF
) ();
   import bspb_pkg::*;
   localparam int OW = VP_SIZE_W + PIXEL_FRAC_BITS;

   logic          valid;
   logic          ready;
   logic          none_projected;
   logic          visible;
   logic          clipped;
   logic [OW-1:0] left;
   logic [OW-1:0] top;
   logic [OW-1:0] right;
   logic [OW-1:0] bottom;

   modport source (output valid, none_projected, visible, clipped, left, top, right,
                   bottom, input ready);
   modport sink (input valid, none_projected, visible, clipped, left, top, right,
                 bottom, output ready);
endinterface
`default_nettype wire

FILE: hdl/bspb_div.sv
// Pipelined radix-2 divider: floor(len * a / b) for 0 <= a <= 2b, one len bit per stage
`default_nettype none
module bspb_div #(
   parameter int DW = 68,
   parameter int LW = 21,
   parameter int QW = 23
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [DW-1:0] a,
   input  wire logic [DW-1:0] b,
   input  wire logic [LW-1:0] len,
   output logic      [QW-1:0] q
);
   logic [DW-1:0] a_ff [LW];
   logic [DW-1:0] b_ff [LW];
   logic [DW-1:0] r_ff [LW];
   logic [QW-1:0] q_ff [LW];

   for (genvar j = 0; j < LW; j++) begin : g_st
      logic [DW-1:0] a_p, b_p, r_p, r2, b2, r3, r4;
      logic [QW-1:0] q_p, q_in;
      logic          ge2, ge1;

      if (j == 0) begin : g_first
         assign a_p = a;
         assign b_p = b;
         assign r_p = '0;
         assign q_p = '0;
      end else begin : g_next
         assign a_p = a_ff[j-1];
         assign b_p = b_ff[j-1];
         assign r_p = r_ff[j-1];
         assign q_p = q_ff[j-1];
      end

      // remainder stays below 4b, so at most two subtractions
      always_comb begin
         r2   = {r_p[DW-2:0], 1'b0} + (len[LW-1-j] ? a_p : '0);
         b2   = {b_p[DW-2:0], 1'b0};
         ge2  = (r2 >= b2);
         r3   = ge2 ? (r2 - b2) : r2;
         ge1  = (r3 >= b_p);
         r4   = ge1 ? (r3 - b_p) : r3;
         q_in = {q_p[QW-2:0], 1'b0} + QW'({ge2, ge1});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[j] <= a_p;
            b_ff[j] <= b_p;
            r_ff[j] <= r4;
            q_ff[j] <= q_in;
         end
      end
   end

   assign q = q_ff[LW-1];
endmodule
`default_nettype wire

FILE: hdl/box_screen_projection_bounds.sv
// Top level: screen-space bounding box of a 3-D box under a stored perspective matrix
//
// Usage
//   req: valid/ready request channel. mode 0 writes one Q16.16 coefficient of the
//     4x4 row-major matrix (no response); mode 1 projects the box given by its min
//     and max corners and yields exactly one response on rsp.
//   rsp: valid/ready channel carrying the clamped pixel box (Q13.8) and flags.
//   csr: write-only viewport registers (left, top, width, height); write only
//     while no box is in flight.
// Throughput: one corner enters the transform each cycle unless the pipeline is
//   held; the eight-corner sequencer takes a new box as the previous box's last corner
//   issues. A coefficient load is taken only while the sequencer is idle or issuing a
//   box's last corner. Stages: products, dot products, divider operands, then
//   LW = 13 + PIXEL_FRAC_BITS divider stages, offsets, accumulation, response register.
// Reset: matrix returns to identity, viewport to 0,0,640x480, pipeline empties.
// Stall: a waiting response holds on rsp and the next one parks in a holding
//   register; only then does the whole pipeline hold, intake included. Nothing is
//   dropped.
`default_nettype none
`include "box_screen_projection_bounds_defines.svh"
module box_screen_projection_bounds #(
   parameter int COORD_WIDTH     = bspb_pkg::COORD_WIDTH_DEF,
   parameter int COORD_FRAC_BITS = bspb_pkg::COORD_FRAC_BITS_DEF,
   parameter int PIXEL_FRAC_BITS = bspb_pkg::PIXEL_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bspb_req_if.sink                               req,
   bspb_rsp_if.source                             rsp,
   input  wire logic                              csr_we,
   input  wire logic [bspb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bspb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bspb_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int FB  = COORD_FRAC_BITS;
   localparam int PRW = (2 * CW > CW + FB) ? 2 * CW : CW + FB;  // product width
   localparam int SW  = PRW + 2;                                // dot-product width
   localparam int DW  = SW + 2;                                 // divider width
   localparam int LW  = VP_SIZE_W + PIXEL_FRAC_BITS;            // scaled length width
   localparam int QW  = LW + 2;
   localparam int PW  = LW + 3;                                 // signed pixel width
   localparam int OW  = LW;                                     // output edge width
   localparam longint unsigned EPS_RAW = (64'd1 << (2 * FB)) / EPS_DEN;
   localparam logic signed [SW-1:0] EPS_S = SW'(EPS_RAW);
   localparam logic signed [PW-1:0] OUT_MAX = PW'((64'd1 << OW) - 1);

   typedef struct packed {
      logic          none_projected;
      logic          visible;
      logic          clipped;
      logic [OW-1:0] left;
      logic [OW-1:0] top;
      logic [OW-1:0] right;
      logic [OW-1:0] bottom;
   } result_type;

   // ---------------- configuration registers ----------------
   logic [VP_POS_W-1:0]  vp_left_ff, vp_top_ff;
   logic [VP_SIZE_W-1:0] vp_w_ff, vp_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_left_ff <= '0;
         vp_top_ff  <= '0;
         vp_w_ff    <= VP_WIDTH_RST;
         vp_h_ff    <= VP_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VP_LEFT:   vp_left_ff <= csr_wdata[VP_POS_W-1:0];
            CSR_VP_TOP:    vp_top_ff  <= csr_wdata[VP_POS_W-1:0];
            CSR_VP_WIDTH:  vp_w_ff    <= csr_wdata[VP_SIZE_W-1:0];
            CSR_VP_HEIGHT: vp_h_ff    <= csr_wdata[VP_SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   logic [LW-1:0] len_x, len_y;
   logic signed [PW-1:0] vx0, vy0, vx1, vy1;
   assign len_x = LW'(vp_w_ff) << PIXEL_FRAC_BITS;
   assign len_y = LW'(vp_h_ff) << PIXEL_FRAC_BITS;
   assign vx0   = PW'(vp_left_ff) <<< PIXEL_FRAC_BITS;
   assign vy0   = PW'(vp_top_ff) <<< PIXEL_FRAC_BITS;
   assign vx1   = vx0 + PW'(len_x);
   assign vy1   = vy0 + PW'(len_y);

   // ---------------- global advance ----------------
   // the whole pipeline moves together; hold it only once a second response is parked
   logic rsp_valid_ff, skid_valid_ff;
   logic adv;
   assign adv = !skid_valid_ff;

   // ---------------- request intake and corner sequencer ----------------
   logic                busy_ff;
   logic [CORNER_W-1:0] cnt_ff;
   logic accept, box_acc, load_acc;

   assign req.ready = adv && (!busy_ff || cnt_ff == CORNER_LAST);
   assign accept    = req.valid && req.ready;
   assign box_acc   = accept && (req.mode == MODE_BOX);
   assign load_acc  = accept && (req.mode == MODE_LOAD);

   logic signed [CW-1:0] bmin_ff [3];
   logic signed [CW-1:0] bmax_ff [3];
   logic signed [CW-1:0] mat_ff [COEF_CNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (adv) begin
         if (box_acc) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CORNER_LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (box_acc) begin
         bmin_ff[0] <= req.box_min_x;
         bmin_ff[1] <= req.box_min_y;
         bmin_ff[2] <= req.box_min_z;
         bmax_ff[0] <= req.box_max_x;
         bmax_ff[1] <= req.box_max_y;
         bmax_ff[2] <= req.box_max_z;
      end
   end

   // matrix: loads land after any corner issued in the same cycle has read it
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_CNT; i++) begin
            mat_ff[i] <= (i % 5 == 0) ? (CW'(1) << FB) : '0;
         end
      end else if (load_acc) begin
         mat_ff[req.coef_index] <= req.coef_value;
      end
   end

   // ---------------- stage 1: products of rows x, y, w ----------------
   logic signed [CW-1:0]  pt [3];
   logic signed [PRW-1:0] prod_in [9];
   logic signed [PRW-1:0] kon_in [3];
   logic signed [PRW-1:0] prod_ff [9];
   logic signed [PRW-1:0] kon_ff [3];
   logic v1_ff, f1_ff, l1_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pt[k] = cnt_ff[k] ? bmax_ff[k] : bmin_ff[k];
      end
      for (int r = 0; r < 3; r++) begin
         // rows 0, 1 and 3 of the matrix
         for (int c = 0; c < 3; c++) begin
            prod_in[r*3+c] = PRW'(mat_ff[(r == 2 ? 3 : r)*4+c]) * PRW'(pt[c]);
         end
         kon_in[r] = PRW'(mat_ff[(r == 2 ? 3 : r)*4+3]) <<< FB;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff   <= (cnt_ff == '0);
         l1_ff   <= (cnt_ff == CORNER_LAST);
         prod_ff <= prod_in;
         kon_ff  <= kon_in;
      end
   end

   // ---------------- stage 2: dot products ----------------
   logic signed [SW-1:0] cx2_ff, cy2_ff, cw2_ff;
   logic v2_ff, f2_ff, l2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_ff  <= f1_ff;
         l2_ff  <= l1_ff;
         cx2_ff <= SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]) + SW'(kon_ff[0]);
         cy2_ff <= SW'(prod_ff[3]) + SW'(prod_ff[4]) + SW'(prod_ff[5]) + SW'(kon_ff[1]);
         cw2_ff <= SW'(prod_ff[6]) + SW'(prod_ff[7]) + SW'(prod_ff[8]) + SW'(kon_ff[2]);
      end
   end

   // ---------------- stage 3: behind test and divider operands ----------------
   logic signed [DW-1:0] ax_s, ay_s, w4_s;
   corner_tag_type       tag3_in, tag3_ff;
   logic [DW-1:0]        ax3_ff, ay3_ff, b3_ff;
   logic                 v3_ff;

   always_comb begin
      ax_s = DW'(cx2_ff) + DW'(cw2_ff);
      ay_s = DW'(cw2_ff) - DW'(cy2_ff);
      w4_s = DW'(cw2_ff) <<< 2;
      tag3_in.first  = f2_ff;
      tag3_in.last   = l2_ff;
      tag3_in.behind = (cw2_ff <= EPS_S) || (vp_w_ff == '0) || (vp_h_ff == '0);
      tag3_in.neg_x  = ax_s < 0;
      tag3_in.over_x = ax_s > w4_s;
      tag3_in.neg_y  = ay_s < 0;
      tag3_in.over_y = ay_s > w4_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag3_ff <= tag3_in;
         ax3_ff  <= ax_s;
         ay3_ff  <= ay_s;
         b3_ff   <= DW'(cw2_ff) << 1;
      end
   end

   // ---------------- divider stages, tags travel alongside ----------------
   logic [QW-1:0]  qx, qy;
   logic           vd_ff [LW];
   corner_tag_type tagd_ff [LW];

   bspb_div #(.DW(DW), .LW(LW), .QW(QW)) u_div_x (
      .clock (clock), .en (adv), .a (ax3_ff), .b (b3_ff), .len (len_x), .q (qx)
   );
   bspb_div #(.DW(DW), .LW(LW), .QW(QW)) u_div_y (
      .clock (clock), .en (adv), .a (ay3_ff), .b (b3_ff), .len (len_y), .q (qy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LW; j++) begin
            vd_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         vd_ff[0] <= v3_ff;
         for (int j = 1; j < LW; j++) begin
            vd_ff[j] <= vd_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tagd_ff[0] <= tag3_ff;
         for (int j = 1; j < LW; j++) begin
            tagd_ff[j] <= tagd_ff[j-1];
         end
      end
   end

   // ---------------- stage 4: saturate offsets, add viewport origin ----------------
   corner_tag_type       tq;
   logic signed [PW-1:0] len1x, len1y, qxs, qys, offx, offy;
   logic signed [PW-1:0] px4_ff, py4_ff;
   logic                 v4_ff, f4_ff, l4_ff, beh4_ff;

   always_comb begin
      tq    = tagd_ff[LW-1];
      len1x = PW'(len_x) + PW'(1);
      len1y = PW'(len_y) + PW'(1);
      qxs   = PW'(qx);
      qys   = PW'(qy);
      if (tq.neg_x)        offx = -PW'(1);
      else if (tq.over_x)  offx = len1x;
      else if (qxs > len1x) offx = len1x;
      else                 offx = qxs;
      if (tq.neg_y)        offy = -PW'(1);
      else if (tq.over_y)  offy = len1y;
      else if (qys > len1y) offy = len1y;
      else                 offy = qys;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= vd_ff[LW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f4_ff   <= tq.first;
         l4_ff   <= tq.last;
         beh4_ff <= tq.behind;
         px4_ff  <= vx0 + offx;
         py4_ff  <= vy0 + offy;
      end
   end

   // ---------------- accumulate over corners, form the response ----------------
   logic                 acc_proj_ff, acc_beh_ff;
   logic signed [PW-1:0] acc_x0_ff, acc_x1_ff, acc_y0_ff, acc_y1_ff;
   logic                 proj_in, beh_in;
   logic signed [PW-1:0] x0_in, x1_in, y0_in, y1_in;
   logic signed [PW-1:0] cx0, cx1, cy0, cy1;
   logic                 clip_c, vis_c;

   always_comb begin
      proj_in = f4_ff ? 1'b0 : acc_proj_ff;
      beh_in  = (f4_ff ? 1'b0 : acc_beh_ff) | beh4_ff;
      x0_in   = acc_x0_ff;
      x1_in   = acc_x1_ff;
      y0_in   = acc_y0_ff;
      y1_in   = acc_y1_ff;
      if (!beh4_ff) begin
         if (!proj_in) begin
            x0_in = px4_ff;
            x1_in = px4_ff;
            y0_in = py4_ff;
            y1_in = py4_ff;
         end else begin
            if (px4_ff < x0_in) x0_in = px4_ff;
            if (px4_ff > x1_in) x1_in = px4_ff;
            if (py4_ff < y0_in) y0_in = py4_ff;
            if (py4_ff > y1_in) y1_in = py4_ff;
         end
         proj_in = 1'b1;
      end
      clip_c = beh_in || (x0_in < vx0) || (y0_in < vy0) || (x1_in > vx1) || (y1_in > vy1);
      cx0    = (x0_in < vx0) ? vx0 : x0_in;
      cy0    = (y0_in < vy0) ? vy0 : y0_in;
      cx1    = (x1_in > vx1) ? vx1 : x1_in;
      cy1    = (y1_in > vy1) ? vy1 : y1_in;
      vis_c  = (cx1 > cx0) && (cy1 > cy0);
   end

   always_ff @(posedge clock) begin
      if (adv && v4_ff) begin
         acc_proj_ff <= proj_in;
         acc_beh_ff  <= beh_in;
         acc_x0_ff   <= x0_in;
         acc_x1_ff   <= x1_in;
         acc_y0_ff   <= y0_in;
         acc_y1_ff   <= y1_in;
      end
   end

   // saturate a pixel edge into the output range
   function automatic logic [OW-1:0] sat_edge(input logic signed [PW-1:0] v);
      logic [OW-1:0] r;
      if (v < 0)            r = '0;
      else if (v > OUT_MAX) r = OUT_MAX[OW-1:0];
      else                  r = v[OW-1:0];
      return r;
   endfunction

   result_type res_c, out_ff, skid_ff;
   logic       fin;
   assign fin = v4_ff && l4_ff;

   always_comb begin
      res_c.none_projected = !proj_in;
      res_c.visible        = proj_in && vis_c;
      res_c.clipped        = proj_in && clip_c;
      res_c.left           = proj_in ? sat_edge(cx0) : '0;
      res_c.top            = proj_in ? sat_edge(cy0) : '0;
      res_c.right          = proj_in ? sat_edge(cx1) : '0;
      res_c.bottom         = proj_in ? sat_edge(cy1) : '0;
   end

   // hold a waiting response; park the next one, then refill from the parked copy
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && !rsp.ready) begin
         if (adv && fin) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && !rsp.ready) begin
         if (adv && fin) begin
            skid_ff <= res_c;
         end
      end else if (skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (fin) begin
         out_ff <= res_c;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.none_projected = out_ff.none_projected;
   assign rsp.visible        = out_ff.visible;
   assign rsp.clipped        = out_ff.clipped;
   assign rsp.left           = out_ff.left;
   assign rsp.top            = out_ff.top;
   assign rsp.right          = out_ff.right;
   assign rsp.bottom         = out_ff.bottom;

   // ---------------- checks ----------------
   `BSPB_ASSERT_SAME(a_no_box_overlap, clock, reset, box_acc && busy_ff, cnt_ff == CORNER_LAST, "box accepted mid-sequence")
   `BSPB_ASSERT_NEXT(a_stall_freezes, clock, reset, !adv, $stable(v4_ff) && $stable(vd_ff[LW-1]), "pipeline moved during stall")
   `BSPB_ASSERT_SAME(a_none_flags, clock, reset, rsp_valid_ff && out_ff.none_projected, !out_ff.visible && !out_ff.clipped, "flags set with nothing projected")
   `BSPB_ASSERT_SAME(a_visible_edges, clock, reset, rsp_valid_ff && out_ff.visible, (out_ff.right >= out_ff.left) && (out_ff.bottom >= out_ff.top), "visible box with inverted edges")

endmodule
`default_nettype wire

FILE: tb/box_screen_projection_bounds_tb.sv
// Self-checking testbench for the screen projection bounds block
`timescale 1ns / 1ps
module box_screen_projection_bounds_tb;
   import bspb_pkg::*;

   localparam int  HALF_PERIOD  = 10;
   localparam int  OUT_W        = VP_SIZE_W + PIXEL_FRAC_BITS_DEF;
   localparam int  OUT_MAX      = (1 << OUT_W) - 1;
   localparam int  ONE_Q16      = 1 << COORD_FRAC_BITS_DEF;
   // leave a margin after draining before any register write
   localparam int  DRAIN_CYCLES = 60;
   localparam int  STALL_LIMIT  = 5000;
   localparam int  PHASE_ITEMS  = 180;
   localparam int  NUM_PHASES   = 6;

   // one request as the sender sees it
   typedef struct {
      logic                    mode;
      logic [COEF_IDX_W-1:0]   idx;
      logic signed [31:0]      val;
      logic signed [31:0]      lo [3];
      logic signed [31:0]      hi [3];
   } box_req_t;

   // one response: flags and clamped pixel edges
   typedef struct {
      logic             none_projected;
      logic             visible;
      logic             clipped;
      logic [OUT_W-1:0] left;
      logic [OUT_W-1:0] top;
      logic [OUT_W-1:0] right;
      logic [OUT_W-1:0] bottom;
   } screen_box_t;

   // one row of the directed table; want holds only where typed is set
   typedef struct {
      box_req_t    rq;
      bit          typed;
      screen_box_t want;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_VP_LEFT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bspb_req_if req_ch ();
   bspb_rsp_if rsp_ch ();

   box_screen_projection_bounds dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor state: its own matrix and viewport copy
   logic signed [31:0] coef_store [COEF_CNT];
   longint vp_left, vp_top, vp_width, vp_height;

   screen_box_t pending_boxes [$];
   directed_row_t directed [$];
   int  fail_count    = 0;
   int  boxes_checked = 0;
   int  loads_sent    = 0;
   int  idle_cycles   = 0;
   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   int  hold_left     = 0;

   // append one expected response to the tail of the queue
   function automatic void queue_expect(screen_box_t b);
      pending_boxes = {pending_boxes, b};
   endfunction

   // append one row to the directed table
   function automatic void add_row(box_req_t rq, bit typed, screen_box_t want);
      directed_row_t row;
      row.rq    = rq;
      row.typed = typed;
      row.want  = want;
      directed  = {directed, row};
   endfunction

   // floor(len * a / b), saturated to -1 .. len + 1
   function automatic longint pixel_offset(logic signed [127:0] a, logic signed [127:0] b,
                                           longint len);
      logic signed [127:0] q;
      if (a < 0) return -1;
      if (a > 2 * b) return len + 1;
      q = (a * len) / b;
      if (q > len + 1) q = len + 1;
      return longint'(q);
   endfunction

   function automatic logic [OUT_W-1:0] clamp_out(longint v);
      if (v < 0) return '0;
      if (v > OUT_MAX) return OUT_MAX[OUT_W-1:0];
      return v[OUT_W-1:0];
   endfunction

   // project the eight corners and build the clamped screen box
   function automatic screen_box_t project_box(box_req_t r);
      screen_box_t res;
      logic signed [127:0] clip_xyw [3];
      logic signed [127:0] mm, pp, eps;
      logic signed [31:0]  corner [3];
      longint lenx, leny, vx0, vy0, vx1, vy1, px, py;
      longint x0, y0, x1, y1;
      int projected, behind;
      bit clp;
      lenx = vp_width << PIXEL_FRAC_BITS_DEF;
      leny = vp_height << PIXEL_FRAC_BITS_DEF;
      vx0  = vp_left << PIXEL_FRAC_BITS_DEF;
      vy0  = vp_top << PIXEL_FRAC_BITS_DEF;
      vx1  = vx0 + lenx;
      vy1  = vy0 + leny;
      // epsilon of 1e-12 rounds to zero at 32 fraction bits
      eps  = (128'd1 << (2 * COORD_FRAC_BITS_DEF)) / EPS_DEN;
      x0 = 0; y0 = 0; x1 = 0; y1 = 0;
      projected = 0;
      behind    = 0;
      for (int i = 0; i < 8; i++) begin
         for (int k = 0; k < 3; k++) corner[k] = i[k] ? r.hi[k] : r.lo[k];
         // rows 0, 1 and 3 give clip x, y and w
         for (int j = 0; j < 3; j++) begin
            int row;
            row = (j == 2) ? 3 : j;
            clip_xyw[j] = 0;
            for (int c = 0; c < 3; c++) begin
               mm = coef_store[row * 4 + c];
               pp = corner[c];
               clip_xyw[j] = clip_xyw[j] + mm * pp;
            end
            mm = coef_store[row * 4 + 3];
            clip_xyw[j] = clip_xyw[j] + mm * ONE_Q16;
         end
         if (clip_xyw[2] <= eps || lenx == 0 || leny == 0) begin
            behind++;
            continue;
         end
         px = vx0 + pixel_offset(clip_xyw[0] + clip_xyw[2], 2 * clip_xyw[2], lenx);
         py = vy0 + pixel_offset(clip_xyw[2] - clip_xyw[1], 2 * clip_xyw[2], leny);
         if (projected == 0) begin
            x0 = px; x1 = px; y0 = py; y1 = py;
         end else begin
            if (px < x0) x0 = px;
            if (px > x1) x1 = px;
            if (py < y0) y0 = py;
            if (py > y1) y1 = py;
         end
         projected++;
      end
      res = '{default: '0};
      if (projected == 0) begin
         res.none_projected = 1'b1;
         return res;
      end
      clp = behind > 0 || x0 < vx0 || y0 < vy0 || x1 > vx1 || y1 > vy1;
      if (x0 < vx0) x0 = vx0;
      if (y0 < vy0) y0 = vy0;
      if (x1 > vx1) x1 = vx1;
      if (y1 > vy1) y1 = vy1;
      res.visible = x1 > x0 && y1 > y0;
      res.clipped = clp;
      res.left    = clamp_out(x0);
      res.top     = clamp_out(y0);
      res.right   = clamp_out(x1);
      res.bottom  = clamp_out(y1);
      return res;
   endfunction

   function automatic box_req_t make_load(int idx, logic signed [31:0] val);
      box_req_t r;
      r = '{mode: MODE_LOAD, idx: idx[COEF_IDX_W-1:0], val: val,
            lo: '{0, 0, 0}, hi: '{0, 0, 0}};
      return r;
   endfunction

   function automatic box_req_t make_box(logic signed [31:0] lx, logic signed [31:0] ly,
                                         logic signed [31:0] lz, logic signed [31:0] hx,
                                         logic signed [31:0] hy, logic signed [31:0] hz);
      box_req_t r;
      r = '{mode: MODE_BOX, idx: '0, val: '0, lo: '{lx, ly, lz}, hi: '{hx, hy, hz}};
      return r;
   endfunction

   function automatic logic signed [31:0] rand_span(int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   // offer one request; advance the predictor once it is accepted
   task automatic send_request(box_req_t r, bit typed, screen_box_t want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= r.mode;
      req_ch.coef_index <= r.idx;
      req_ch.coef_value <= r.val;
      req_ch.box_min_x  <= r.lo[0];
      req_ch.box_min_y  <= r.lo[1];
      req_ch.box_min_z  <= r.lo[2];
      req_ch.box_max_x  <= r.hi[0];
      req_ch.box_max_y  <= r.hi[1];
      req_ch.box_max_z  <= r.hi[2];
      do @(posedge clock); while (!req_ch.ready);
      if (r.mode == MODE_LOAD) begin
         coef_store[r.idx] = r.val;
         loads_sent++;
      end else begin
         queue_expect(typed ? want : project_box(r));
      end
      @(negedge clock);
   endtask

   task automatic send_predicted(box_req_t r);
      screen_box_t unused;
      unused = '{default: '0};
      send_request(r, 1'b0, unused);
   endtask

   // drain, then write all four viewport registers on consecutive cycles
   task automatic set_viewport(logic [CSR_DATA_W-1:0] l, logic [CSR_DATA_W-1:0] t,
                               logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h);
      logic [CSR_DATA_W-1:0] vals [4];
      logic [CSR_IDX_W-1:0]  regs [4];
      vals = '{l, t, w, h};
      regs = '{CSR_VP_LEFT, CSR_VP_TOP, CSR_VP_WIDTH, CSR_VP_HEIGHT};
      req_ch.valid <= 1'b0;
      while (pending_boxes.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      vp_left   = l & 13'hFFF;
      vp_top    = t & 13'hFFF;
      vp_width  = w;
      vp_height = h;
   endtask

   // a clean perspective-like matrix keeps most corners in front of the camera
   task automatic load_clean_matrix();
      for (int i = 0; i < COEF_CNT; i++) begin
         logic signed [31:0] v;
         if (i == 15) v = $urandom_range(1 << 18, 1 << 14);
         else if (i == 12 || i == 13 || i == 14) v = rand_span(1 << 12);
         else if (i % 5 == 0) v = rand_span(1 << 17);
         else v = rand_span(1 << 15);
         send_predicted(make_load(i, v));
      end
   endtask

   task automatic random_request();
      int pick;
      pick = $urandom_range(99);
      if (pick < 85) begin
         logic signed [31:0] a [3];
         logic signed [31:0] b [3];
         for (int k = 0; k < 3; k++) begin
            a[k] = rand_span(1 << 18);
            b[k] = a[k] + $urandom_range(1 << 18);
         end
         send_predicted(make_box(a[0], a[1], a[2], b[0], b[1], b[2]));
      end else if (pick < 92) begin
         send_predicted(make_box($urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom));
      end else begin
         send_predicted(make_load($urandom_range(15), $urandom));
      end
   endtask

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // receiver: a long hold-off when asked, random stalls otherwise
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // compare each response with the oldest expectation; watchdog on no progress
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request or response moved in %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_boxes.size() == 0) begin
               $error("response with no box outstanding");
               fail_count++;
            end else begin
               screen_box_t want;
               want = pending_boxes.pop_front();
               check_field("none_projected", want.none_projected, rsp_ch.none_projected);
               check_field("visible", want.visible, rsp_ch.visible);
               check_field("clipped", want.clipped, rsp_ch.clipped);
               check_field("left", want.left, rsp_ch.left);
               check_field("top", want.top, rsp_ch.top);
               check_field("right", want.right, rsp_ch.right);
               check_field("bottom", want.bottom, rsp_ch.bottom);
               boxes_checked++;
            end
         end
      end
   end

   initial begin
      screen_box_t nothing;
      logic signed [31:0] one, mneg, mpos;
      one  = ONE_Q16;
      mneg = 32'sh8000_0000;
      mpos = 32'sh7FFF_FFFF;
      nothing = '{none_projected: 1'b1, default: '0};

      req_ch.valid      = 1'b0;
      req_ch.mode       = MODE_LOAD;
      req_ch.coef_index = '0;
      req_ch.coef_value = '0;
      req_ch.box_min_x  = '0;
      req_ch.box_min_y  = '0;
      req_ch.box_min_z  = '0;
      req_ch.box_max_x  = '0;
      req_ch.box_max_y  = '0;
      req_ch.box_max_z  = '0;
      rsp_ch.ready      = 1'b0;

      // predictor reset: identity matrix, 640x480 viewport at the origin
      for (int i = 0; i < COEF_CNT; i++) coef_store[i] = (i % 5 == 0) ? one : 0;
      vp_left = 0; vp_top = 0;
      vp_width = VP_WIDTH_RST; vp_height = VP_HEIGHT_RST;

      // directed table: unit cube face fills the viewport, origin lands mid-screen
      add_row(make_box(-one, -one, 0, one, one, 0), 1'b1,
              '{0, 1, 0, 0, 0, 163840, 122880});
      add_row(make_box(0, 0, 0, 0, 0, 0), 1'b1,
              '{0, 0, 0, 81920, 61440, 81920, 61440});
      add_row(make_box(mneg, mneg, mneg, mpos, mpos, mpos), 1'b0, nothing);
      add_row(make_box(2 * one, 2 * one, 0, 3 * one, 3 * one, 0), 1'b0, nothing);
      add_row(make_box(-3 * one, -one, 0, -2 * one, one, 0), 1'b0, nothing);
      // w forced to zero: every corner is behind
      add_row(make_load(15, 0), 1'b0, nothing);
      add_row(make_box(-one, -one, -one, one, one, one), 1'b1, nothing);
      add_row(make_load(15, mpos), 1'b0, nothing);
      add_row(make_load(14, mneg), 1'b0, nothing);
      // some corners behind, some in front
      add_row(make_box(-one, -one, -one, one, one, one), 1'b0, nothing);
      add_row(make_load(14, 0), 1'b0, nothing);
      add_row(make_load(15, one), 1'b0, nothing);
      add_row(make_load(0, 2 * one), 1'b0, nothing);
      add_row(make_load(3, -(one / 2)), 1'b0, nothing);
      add_row(make_box(-one, -one, 0, one / 2, one / 3, one), 1'b0, nothing);
      add_row(make_load(13, one / 4), 1'b0, nothing);
      add_row(make_box(-one, -one, 0, one, one, 0), 1'b0, nothing);
      add_row(make_load(0, one), 1'b0, nothing);
      add_row(make_load(3, 0), 1'b0, nothing);
      add_row(make_load(13, 0), 1'b0, nothing);

      // hold reset, then release it on a falling edge
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) send_request(directed[i].rq, directed[i].typed, directed[i].want);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: set_viewport(13'd0, 13'd0, 13'd640, 13'd480);
            // widest viewport; left/top carry a stray top bit that must be dropped
            1: set_viewport(13'h1FFF, 13'h1FFF, 13'd4096, 13'd4096);
            2: set_viewport(13'd5, 13'd7, 13'd0, 13'd480);
            3: set_viewport(13'd100, 13'd50, 13'd640, 13'd0);
            4: set_viewport(13'd1, 13'd1, 13'd1, 13'd1);
            default: set_viewport(13'($urandom_range(4095)), 13'($urandom_range(4095)),
                                  13'($urandom_range(4096, 1)),
                                  13'($urandom_range(4096, 1)));
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 14; stall_pct = 14; end
         endcase
         // last phase: hold the response side off so the pipeline backs up
         if (ph == NUM_PHASES - 1) hold_left = 400;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 45 == 0) load_clean_matrix();
            random_request();
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_boxes.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d boxes checked and %0d coefficient loads", boxes_checked,
               loads_sent);
      $display("over six viewport settings, zero sizes and the widest among them");
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
